// ===== sv/mvp_pkg.sv =====
// shared widths, fixed-point constants and types of the mvp matrix builder
package mvp_pkg;

   localparam int ANGLE_W     = 19;
   localparam int IDX_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int REG_W       = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 1'd1;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd800;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd600;

   // q30 fixed point
   localparam int Q_BITS      = 30;
   localparam int ANGLE_SHIFT = 14;
   localparam int X_W         = ANGLE_W + ANGLE_SHIFT;  // 33
   localparam int R_W         = 30;                      // reduced angle, at most pi/4
   localparam int MAG_W       = 31;                      // sin/cos magnitude, at most 1.0
   localparam int G_W         = 45;                      // focal*height/width
   localparam int AHI_W       = G_W - Q_BITS;

   localparam logic [X_W-1:0]   TWO_PI_Q30     = 33'd6746518852;
   localparam logic [X_W-1:0]   HALF_PI_Q30    = 33'd1686629713;
   localparam logic [X_W-1:0]   QUARTER_PI_Q30 = 33'd843314857;
   localparam logic [MAG_W-1:0] ONE_Q30        = 31'd1073741824;
   localparam logic [31:0]      FOCAL_Q30      = 32'd2592242074;
   localparam logic [31:0]      DEPTH_A_Q30    =
      32'(((64'd1001 << 30) + 64'd499) / 64'd999);
   localparam logic [31:0]      DEPTH_T_Q30    =
      32'(((64'd2803 << 30) + 64'd499) / 64'd999);
   localparam logic [31:0]      THREE_Q30      = 32'd3221225472;

   localparam int QUEUE_DEPTH = 4;

   // matrix positions, column-major
   localparam logic [IDX_W-1:0] EL_G_COS = 4'd0;
   localparam logic [IDX_W-1:0] EL_A_SIN = 4'd2;
   localparam logic [IDX_W-1:0] EL_SIN   = 4'd3;
   localparam logic [IDX_W-1:0] EL_FOCAL = 4'd5;
   localparam logic [IDX_W-1:0] EL_G_SIN = 4'd8;
   localparam logic [IDX_W-1:0] EL_A_COS = 4'd10;
   localparam logic [IDX_W-1:0] EL_COS   = 4'd11;
   localparam logic [IDX_W-1:0] EL_DEPTH = 4'd14;
   localparam logic [IDX_W-1:0] EL_LAST  = 4'd15;

   typedef struct packed {
      logic [R_W-1:0] r;
      logic [1:0]     quad;
      logic           swap;
   } trig_item_type;

   typedef struct packed {
      logic [MAG_W-1:0] s_mag;
      logic [MAG_W-1:0] c_mag;
      logic             s_neg;
      logic             s_pos;
      logic             c_neg;
      logic             c_pos;
   } sincos_type;

endpackage

// ===== sv/mvp_req_if.sv =====
// angle channel interface
interface mvp_req_if;
   import mvp_pkg::*;

   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] rotation_angle;

   modport source (output valid, output rotation_angle, input ready);
   modport sink   (input valid, input rotation_angle, output ready);
endinterface

// ===== sv/mvp_rsp_if.sv =====
// matrix element channel interface
interface mvp_rsp_if;
   import mvp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [IDX_W-1:0]          element_index;
   logic signed [VALUE_W-1:0] element_value;
   logic                      last_element;

   modport source (output valid, output element_index, output element_value,
                   output last_element, input ready);
   modport sink   (input valid, input element_index, input element_value,
                   input last_element, output ready);
endinterface

// ===== sv/mvp_front.sv =====
// front end: angle intake, 2*pi wrap, quadrant and octant fold
module mvp_front (
   input  logic                  clock,
   input  logic                  reset,
   mvp_req_if.sink               req,
   output logic                  push_valid,
   output mvp_pkg::trig_item_type push_item,
   input  logic                  push_ready
);
   import mvp_pkg::*;

   logic           st_valid_ff;
   logic [X_W-1:0] st_x_ff;
   logic [X_W-1:0] x_wide;
   logic [X_W-1:0] x_wrap;
   logic           accept;
   logic           ge1, ge2, ge3;
   logic [X_W-1:0] base;
   logic [X_W-1:0] rem;

   assign req.ready = !st_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   assign x_wide = {req.rotation_angle, {ANGLE_SHIFT{1'b0}}};
   assign x_wrap = (x_wide >= TWO_PI_Q30) ? x_wide - TWO_PI_Q30 : x_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (accept) begin
         st_valid_ff <= 1'b1;
      end else if (push_ready) begin
         st_valid_ff <= 1'b0;
      end
      if (accept) begin
         st_x_ff <= x_wrap;
      end
   end

   // quadrant by parallel compares against multiples of pi/2
   assign ge1 = st_x_ff >= HALF_PI_Q30;
   assign ge2 = st_x_ff >= 33'(HALF_PI_Q30 * 2);
   assign ge3 = st_x_ff >= 33'(HALF_PI_Q30 * 3);

   always_comb begin
      priority if (ge3) begin
         push_item.quad = 2'd3;
         base = 33'(HALF_PI_Q30 * 3);
      end else if (ge2) begin
         push_item.quad = 2'd2;
         base = 33'(HALF_PI_Q30 * 2);
      end else if (ge1) begin
         push_item.quad = 2'd1;
         base = HALF_PI_Q30;
      end else begin
         push_item.quad = 2'd0;
         base = '0;
      end
      rem = st_x_ff - base;
      push_item.swap = rem > QUARTER_PI_Q30;
      push_item.r = push_item.swap ? R_W'(HALF_PI_Q30 - rem) : rem[R_W-1:0];
   end

   assign push_valid = st_valid_ff;

endmodule

// ===== sv/mvp_queue.sv =====
// short queue between the front end and the trig unit
module mvp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  mvp_pkg::trig_item_type push_item,
   output logic                  push_ready,
   output logic                  pop_valid,
   output mvp_pkg::trig_item_type pop_item,
   input  logic                  pop
);
   import mvp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   trig_item_type    entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'((CNT_W'(wr_ptr_ff) + 1'b1) % CNT_W'(QUEUE_DEPTH));
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'((CNT_W'(rd_ptr_ff) + 1'b1) % CNT_W'(QUEUE_DEPTH));
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(QUEUE_DEPTH) && !do_pop) |=> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("queue lost an entry while full");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");

endmodule

// ===== sv/mvp_trig.sv =====
// sin/cos unit: two interleaved taylor chains on a shared term pipeline
module mvp_trig (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  mvp_pkg::trig_item_type item,
   output logic                   item_pop,
   output logic                   sc_valid,
   output mvp_pkg::sincos_type    sc,
   input  logic                   sc_ready
);
   import mvp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [2:0] SIN_TERMS = 3'd6;
   localparam logic [2:0] COS_TERMS = 3'd7;

   // divisor of term k: (2k)(2k+1) for sin, (2k-1)(2k) for cos
   function automatic logic [7:0] term_div(input logic is_cos, input logic [2:0] k);
      logic [7:0] d;
      begin
         d = 8'd1;
         unique case ({is_cos, k})
            4'b0001: d = 8'd6;
            4'b0010: d = 8'd20;
            4'b0011: d = 8'd42;
            4'b0100: d = 8'd72;
            4'b0101: d = 8'd110;
            4'b0110: d = 8'd156;
            4'b1001: d = 8'd2;
            4'b1010: d = 8'd12;
            4'b1011: d = 8'd30;
            4'b1100: d = 8'd56;
            4'b1101: d = 8'd90;
            4'b1110: d = 8'd132;
            4'b1111: d = 8'd182;
            default: d = 8'd1;
         endcase
         return d;
      end
   endfunction

   // floor(2^32 / divisor)
   function automatic logic [31:0] term_recip(input logic is_cos, input logic [2:0] k);
      logic [31:0] r;
      begin
         r = 32'hFFFF_FFFF;
         unique case ({is_cos, k})
            4'b0001: r = 32'd715827882;
            4'b0010: r = 32'd214748364;
            4'b0011: r = 32'd102261126;
            4'b0100: r = 32'd59652323;
            4'b0101: r = 32'd39045157;
            4'b0110: r = 32'd27531841;
            4'b1001: r = 32'd2147483648;
            4'b1010: r = 32'd357913941;
            4'b1011: r = 32'd143165576;
            4'b1100: r = 32'd76695844;
            4'b1101: r = 32'd47721858;
            4'b1110: r = 32'd32537631;
            4'b1111: r = 32'd23598721;
            default: r = 32'hFFFF_FFFF;
         endcase
         return r;
      end
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [R_W-1:0]   x2_ff;
   logic [1:0]       quad_ff;
   logic             swap_ff;
   logic [MAG_W-1:0] sin_term_ff, cos_term_ff;
   logic [MAG_W-1:0] sin_sum_ff, cos_sum_ff;
   logic [2:0]       sin_k_ff, cos_k_ff;
   logic             sin_busy_ff, cos_busy_ff;

   logic             t1_valid_ff, t1_ch_ff;
   logic [2:0]       t1_k_ff;
   logic [MAG_W-1:0] t1_p_ff;
   logic             t2_valid_ff, t2_ch_ff;
   logic [2:0]       t2_k_ff;
   logic [MAG_W-1:0] t2_p_ff;
   logic [MAG_W-1:0] t2_q0_ff;

   logic             load;
   logic [60:0]      x2_prod;
   logic             iss_sin, iss_cos, iss;
   logic             iss_ch;
   logic [MAG_W-1:0] iss_t;
   logic [2:0]       iss_k;
   logic [61:0]      t_prod;
   logic [62:0]      r_prod;
   logic [7:0]       wb_d;
   logic [38:0]      wb_qd;
   logic [31:0]      wb_rem;
   logic [MAG_W-1:0] wb_q;
   logic [MAG_W-1:0] wb_sum_old, wb_sum_new;
   logic             chains_done;
   logic [MAG_W-1:0] rs, rc;
   logic             c_neg_q;

   assign load    = (state_ff == ST_IDLE) && item_valid;
   assign item_pop = load;
   assign x2_prod = 61'(item.r) * 61'(item.r) + (61'd1 << (Q_BITS - 1));

   // issue: sin first, cos when its chain is free
   assign iss_sin = (state_ff == ST_RUN) && !sin_busy_ff && (sin_k_ff < SIN_TERMS);
   assign iss_cos = (state_ff == ST_RUN) && !cos_busy_ff && (cos_k_ff < COS_TERMS)
                    && !iss_sin;
   assign iss     = iss_sin || iss_cos;
   assign iss_ch  = iss_cos;
   assign iss_t   = iss_ch ? cos_term_ff : sin_term_ff;
   assign iss_k   = (iss_ch ? cos_k_ff : sin_k_ff) + 3'd1;

   assign t_prod = 62'(iss_t) * 62'(x2_ff) + (62'd1 << (Q_BITS - 1));
   assign r_prod = 63'(t1_p_ff) * 63'(term_recip(t1_ch_ff, t1_k_ff));

   // reciprocal quotient is exact or one low
   assign wb_d       = term_div(t2_ch_ff, t2_k_ff);
   assign wb_qd      = 39'(t2_q0_ff) * 39'(wb_d);
   assign wb_rem     = 32'(t2_p_ff) - wb_qd[31:0];
   assign wb_q       = (wb_rem >= 32'(wb_d)) ? t2_q0_ff + 1'b1 : t2_q0_ff;
   assign wb_sum_old = t2_ch_ff ? cos_sum_ff : sin_sum_ff;
   assign wb_sum_new = t2_k_ff[0] ? wb_sum_old - wb_q : wb_sum_old + wb_q;

   assign chains_done = (sin_k_ff == SIN_TERMS) && (cos_k_ff == COS_TERMS)
                        && !sin_busy_ff && !cos_busy_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (item_valid) state_in = ST_RUN;
         ST_RUN:  if (chains_done) state_in = ST_DONE;
         ST_DONE: if (sc_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sin_busy_ff <= 1'b0;
         cos_busy_ff <= 1'b0;
         sin_k_ff    <= '0;
         cos_k_ff    <= '0;
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         t1_valid_ff <= iss;
         t2_valid_ff <= t1_valid_ff;
         if (load) begin
            sin_k_ff    <= '0;
            cos_k_ff    <= '0;
            sin_busy_ff <= 1'b0;
            cos_busy_ff <= 1'b0;
         end else begin
            if (iss_sin) begin
               sin_busy_ff <= 1'b1;
            end else if (t2_valid_ff && !t2_ch_ff) begin
               sin_busy_ff <= 1'b0;
               sin_k_ff    <= t2_k_ff;
            end
            if (iss_cos) begin
               cos_busy_ff <= 1'b1;
            end else if (t2_valid_ff && t2_ch_ff) begin
               cos_busy_ff <= 1'b0;
               cos_k_ff    <= t2_k_ff;
            end
         end
      end

      if (load) begin
         x2_ff       <= x2_prod[59:30];
         quad_ff     <= item.quad;
         swap_ff     <= item.swap;
         sin_term_ff <= MAG_W'(item.r);
         sin_sum_ff  <= MAG_W'(item.r);
         cos_term_ff <= ONE_Q30;
         cos_sum_ff  <= ONE_Q30;
      end else if (t2_valid_ff) begin
         if (t2_ch_ff) begin
            cos_term_ff <= wb_q;
            cos_sum_ff  <= wb_sum_new;
         end else begin
            sin_term_ff <= wb_q;
            sin_sum_ff  <= wb_sum_new;
         end
      end

      t1_ch_ff <= iss_ch;
      t1_k_ff  <= iss_k;
      t1_p_ff  <= t_prod[60:30];
      t2_ch_ff <= t1_ch_ff;
      t2_k_ff  <= t1_k_ff;
      t2_p_ff  <= t1_p_ff;
      t2_q0_ff <= r_prod[62:32];
   end

   // undo the octant fold, then place by quadrant
   assign rs       = swap_ff ? cos_sum_ff : sin_sum_ff;
   assign rc       = swap_ff ? sin_sum_ff : cos_sum_ff;
   assign c_neg_q  = quad_ff[0] ^ quad_ff[1];
   assign sc.s_mag = quad_ff[0] ? rc : rs;
   assign sc.c_mag = quad_ff[0] ? rs : rc;
   assign sc.s_neg = quad_ff[1] && (sc.s_mag != '0);
   assign sc.s_pos = !quad_ff[1] && (sc.s_mag != '0);
   assign sc.c_neg = c_neg_q && (sc.c_mag != '0);
   assign sc.c_pos = !c_neg_q && (sc.c_mag != '0);
   assign sc_valid = state_ff == ST_DONE;

   a_wb_inflight: assert property (@(posedge clock) disable iff (reset)
      t2_valid_ff |-> (t2_ch_ff ? cos_busy_ff : sin_busy_ff))
      else $error("term written back to an idle chain");

   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      (sin_k_ff <= SIN_TERMS) && (cos_k_ff <= COS_TERMS))
      else $error("taylor chain ran past its last term");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!t1_valid_ff && !t2_valid_ff))
      else $error("result offered with terms still in flight");

endmodule

// ===== sv/mvp_elem.sv =====
// back end: aspect divider and element pipeline with registered output
module mvp_elem #(
   parameter int FRAC_BITS = mvp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mvp_pkg::REG_W-1:0] surface_width,
   input  logic [mvp_pkg::REG_W-1:0] surface_height,
   input  logic                      cfg_written,
   input  logic                      sc_valid,
   input  mvp_pkg::sincos_type       sc,
   output logic                      sc_ready,
   mvp_rsp_if.source                 rsp
);
   import mvp_pkg::*;

   localparam int U_SHIFT = Q_BITS - FRAC_BITS;
   localparam int QW      = AHI_W + MAG_W + 1;
   localparam logic [QW-1:0] ROUND_HALF = QW'(1) << (U_SHIFT - 1);
   localparam int DIV_CNT_W = $clog2(G_W + 1);

   // aspect divider: g = (focal*height + width/2) / width, one bit a cycle
   logic                 div_pend_ff;
   logic                 div_busy_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [G_W-1:0]       div_num_ff;
   logic [REG_W-1:0]     div_rem_ff;
   logic                 g_valid_ff;
   logic [REG_W-1:0]     w_eff;
   logic [REG_W:0]       div_trial;
   logic                 div_ge;

   assign w_eff     = (surface_width == '0) ? REG_W'(1) : surface_width;
   assign div_trial = {div_rem_ff, div_num_ff[G_W-1]};
   assign div_ge    = div_trial >= {1'b0, w_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_pend_ff <= 1'b1;
         div_busy_ff <= 1'b0;
         g_valid_ff  <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cfg_written) begin
         div_pend_ff <= 1'b1;
         div_busy_ff <= 1'b0;
         g_valid_ff  <= 1'b0;
      end else if (div_pend_ff) begin
         div_pend_ff <= 1'b0;
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DIV_CNT_W'(G_W);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (div_cnt_ff == DIV_CNT_W'(1)) begin
            div_busy_ff <= 1'b0;
            g_valid_ff  <= 1'b1;
         end
      end
      if (div_pend_ff) begin
         div_num_ff <= G_W'(FOCAL_Q30) * G_W'(surface_height) + G_W'(w_eff >> 1);
         div_rem_ff <= '0;
      end else if (div_busy_ff) begin
         div_rem_ff <= div_ge ? REG_W'(div_trial - {1'b0, w_eff}) : div_trial[REG_W-1:0];
         div_num_ff <= {div_num_ff[G_W-2:0], div_ge};
      end
   end

   // element sequencer
   logic             busy_ff;
   logic [IDX_W-1:0] idx_ff;
   sincos_type       sc_ff;
   logic             adv;
   logic             issue;
   logic [G_W-1:0]   a_sel;
   logic [MAG_W-1:0] b_sel;
   logic             neg_sel;

   logic                     e1_valid_ff, e2_valid_ff, e3_valid_ff, o_valid_ff;
   logic [60:0]              e1_plo_ff, e2_plo_ff;
   logic [AHI_W-1:0]         e1_ahi_ff;
   logic [MAG_W-1:0]         e1_b_ff;
   logic [AHI_W+MAG_W-1:0]   e2_phi_ff;
   logic [QW-1:0]            e3_q_ff;
   logic                     e1_neg_ff, e2_neg_ff, e3_neg_ff;
   logic [IDX_W-1:0]         e1_idx_ff, e2_idx_ff, e3_idx_ff, o_idx_ff;
   logic [VALUE_W-1:0]       o_value_ff;
   logic                     o_last_ff;
   logic [QW-1:0]            rnd;
   logic [QW-1:0]            mag;
   logic                     over;
   logic [VALUE_W-1:0]       value_in;

   assign adv      = !o_valid_ff || rsp.ready;
   assign sc_ready = !busy_ff;
   assign issue    = busy_ff && g_valid_ff && adv;

   always_comb begin
      a_sel   = '0;
      b_sel   = ONE_Q30;
      neg_sel = 1'b0;
      unique case (idx_ff)
         EL_G_COS: begin a_sel = div_num_ff; b_sel = sc_ff.c_mag; neg_sel = sc_ff.c_neg; end
         EL_A_SIN: begin a_sel = G_W'(DEPTH_A_Q30); b_sel = sc_ff.s_mag;
                         neg_sel = sc_ff.s_pos; end
         EL_SIN:   begin a_sel = G_W'(ONE_Q30); b_sel = sc_ff.s_mag; neg_sel = sc_ff.s_pos; end
         EL_FOCAL: begin a_sel = G_W'(FOCAL_Q30); end
         EL_G_SIN: begin a_sel = div_num_ff; b_sel = sc_ff.s_mag; neg_sel = sc_ff.s_pos; end
         EL_A_COS: begin a_sel = G_W'(DEPTH_A_Q30); b_sel = sc_ff.c_mag;
                         neg_sel = sc_ff.c_pos; end
         EL_COS:   begin a_sel = G_W'(ONE_Q30); b_sel = sc_ff.c_mag; neg_sel = sc_ff.c_pos; end
         EL_DEPTH: begin a_sel = G_W'(DEPTH_T_Q30); end
         EL_LAST:  begin a_sel = G_W'(THREE_Q30); end
         default:  begin a_sel = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         idx_ff      <= '0;
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         if (sc_valid && sc_ready) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == EL_LAST) begin
               busy_ff <= 1'b0;
            end
         end
         if (adv) begin
            e1_valid_ff <= issue;
            e2_valid_ff <= e1_valid_ff;
            e3_valid_ff <= e2_valid_ff;
            o_valid_ff  <= e3_valid_ff;
         end
      end
      if (sc_valid && sc_ready) begin
         sc_ff <= sc;
      end
      if (adv) begin
         e1_plo_ff  <= 61'(a_sel[Q_BITS-1:0]) * 61'(b_sel);
         e1_ahi_ff  <= a_sel[G_W-1:Q_BITS];
         e1_b_ff    <= b_sel;
         e1_neg_ff  <= neg_sel;
         e1_idx_ff  <= idx_ff;
         e2_phi_ff  <= (AHI_W+MAG_W)'(e1_ahi_ff) * (AHI_W+MAG_W)'(e1_b_ff);
         e2_plo_ff  <= e1_plo_ff;
         e2_neg_ff  <= e1_neg_ff;
         e2_idx_ff  <= e1_idx_ff;
         e3_q_ff    <= QW'(e2_phi_ff) + QW'(e2_plo_ff[60:30]);
         e3_neg_ff  <= e2_neg_ff;
         e3_idx_ff  <= e2_idx_ff;
         o_value_ff <= value_in;
         o_idx_ff   <= e3_idx_ff;
         o_last_ff  <= e3_idx_ff == EL_LAST;
      end
   end

   // round half away from zero on the magnitude, then sign and saturate
   assign rnd  = e3_q_ff + ROUND_HALF;
   assign mag  = rnd >> U_SHIFT;
   assign over = |mag[QW-1:VALUE_W-1];
   always_comb begin
      if (e3_neg_ff) begin
         value_in = over ? 32'h8000_0000 : -mag[VALUE_W-1:0];
      end else begin
         value_in = over ? 32'h7FFF_FFFF : mag[VALUE_W-1:0];
      end
   end

   assign rsp.valid         = o_valid_ff;
   assign rsp.element_index = o_idx_ff;
   assign rsp.element_value = o_value_ff;
   assign rsp.last_element  = o_last_ff;

   a_issue_needs_g: assert property (@(posedge clock) disable iff (reset)
      issue |-> (g_valid_ff && !div_busy_ff && !div_pend_ff))
      else $error("element issued before the aspect quotient was ready");

   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (o_last_ff == (o_idx_ff == EL_LAST)))
      else $error("last flag out of step with the element position");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      (e1_valid_ff && adv && e1_idx_ff != EL_LAST) |=> (idx_ff != '0 || !busy_ff || !e1_valid_ff
         || e1_idx_ff == $past(e1_idx_ff) + 1'b1))
      else $error("element positions issued out of order");

endmodule

// ===== sv/perspective_mvp_matrix_builder.sv =====
// top level of the perspective model-view-projection matrix builder
//
// usage
//   req_ch carries one rotation angle per transaction (unsigned q3.16 radians).
//   rsp_ch returns sixteen transactions per angle: the column-major elements of
//   proj*view*model in signed q(32-FRAC_BITS).FRAC_BITS, last_element on index 15.
//   csr_* writes surface width (index 0) and height (index 1); write only when idle.
// sequencing
//   the sin/cos unit takes one angle at a time: it loads the angle, runs the term
//   loop shared by the sin and cos chains (six sin terms, seven cos terms), drains
//   the last term and hands off the result; the sixteen elements of an angle leave
//   back to back when the receiver keeps ready high
// reset
//   width 800, height 600; the aspect divider then runs, and again after every
//   csr write; angles are taken meanwhile but no element leaves before it ends
// receiver stall
//   the output register holds its transaction, the element pipeline freezes, the
//   sin/cos unit holds its result, and the four-entry queue absorbs angles until full
module perspective_mvp_matrix_builder #(
   parameter int FRAC_BITS = mvp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   mvp_req_if.sink                         req_ch,
   mvp_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  logic [mvp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mvp_pkg::REG_W-1:0]       csr_wdata
);
   import mvp_pkg::*;

   // configuration registers
   logic [REG_W-1:0] width_ff;
   logic [REG_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // front end to queue
   logic          push_valid;
   logic          push_ready;
   trig_item_type push_item;

   // queue to sin/cos unit
   logic          pop_valid;
   logic          pop;
   trig_item_type pop_item;

   // sin/cos unit to element pipeline
   logic          sc_valid;
   logic          sc_ready;
   sincos_type    sc;

   mvp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   mvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   mvp_trig u_trig (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .sc_valid   (sc_valid),
      .sc         (sc),
      .sc_ready   (sc_ready)
   );

   // any write restarts the aspect divider
   mvp_elem #(
      .FRAC_BITS (FRAC_BITS)
   ) u_elem (
      .clock          (clock),
      .reset          (reset),
      .surface_width  (width_ff),
      .surface_height (height_ff),
      .cfg_written    (csr_write_en),
      .sc_valid       (sc_valid),
      .sc             (sc),
      .sc_ready       (sc_ready),
      .rsp            (rsp_ch)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for the perspective model-view-projection matrix builder
module tb;
   import mvp_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 120;
   localparam int LONG_HOLD      = 300;

   // fixed-point constants of the predictor, q30
   localparam longint unsigned ONE30     = 64'd1073741824;
   localparam longint unsigned HALF_PI30 = 64'd1686629713;
   localparam longint unsigned QTR_PI30  = 64'd843314857;
   localparam longint unsigned TWO_PI30  = 64'd6746518852;
   localparam longint unsigned FOCAL30   = 64'd2592242074;
   localparam longint unsigned A30       = ((64'd1001 << 30) + 64'd499) / 64'd999;
   localparam longint unsigned T30       = ((64'd2803 << 30) + 64'd499) / 64'd999;
   localparam int FRAC = FRAC_BITS_DEFAULT;

   typedef struct {
      logic [IDX_W-1:0]   index;
      logic [VALUE_W-1:0] value;
      logic               last;
   } element_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_WIDTH;
   logic [REG_W-1:0] csr_wdata = '0;

   mvp_req_if req_ch ();
   mvp_rsp_if rsp_ch ();

   perspective_mvp_matrix_builder DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor's copy of the aspect registers
   logic [REG_W-1:0] model_width  = WIDTH_RESET;
   logic [REG_W-1:0] model_height = HEIGHT_RESET;

   logic [ANGLE_W-1:0] angle_backlog[$];
   element_type        pending_elements[$];
   int mismatches = 0;
   int angles_sent = 0;
   int elements_seen = 0;
   int idle_cycles = 0;
   logic hold_request = 1'b0;

   // ---------------- predictor ----------------

   function automatic longint unsigned round_sq(longint unsigned t, longint unsigned x2);
      return (t * x2 + (64'd1 << 29)) >> 30;
   endfunction

   // taylor series of sin (to x^13) and cos (to x^14) in q30
   function automatic void series_sincos(input longint unsigned x,
                                         output longint sv, output longint cv);
      longint unsigned x2, term;
      longint acc;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         term = round_sq(term, x2) / longint'((2 * k) * (2 * k + 1));
         acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      sv = acc;
      term = ONE30;
      acc = longint'(ONE30);
      for (int k = 1; k <= 7; k++) begin
         term = round_sq(term, x2) / longint'((2 * k - 1) * (2 * k));
         acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      cv = acc;
   endfunction

   function automatic void angle_sincos(input logic [ANGLE_W-1:0] angle,
                                        output longint sv, output longint cv);
      longint unsigned x;
      int quad;
      longint rs, rc;
      x = longint'(angle) << 14;
      quad = 0;
      if (x >= TWO_PI30) x -= TWO_PI30;
      while (quad < 3 && x >= HALF_PI30) begin
         x -= HALF_PI30;
         quad++;
      end
      // past pi/4 the complement is used and the roles swap
      if (x > QTR_PI30) series_sincos(HALF_PI30 - x, rc, rs);
      else series_sincos(x, rs, rc);
      case (quad)
         0: begin sv = rs;  cv = rc;  end
         1: begin sv = rc;  cv = -rs; end
         2: begin sv = -rs; cv = -rc; end
         default: begin sv = -rc; cv = rs; end
      endcase
   endfunction

   // product of two q30 magnitudes, rounded half away from zero, signed, saturated
   function automatic logic [31:0] scaled_element(logic neg, longint unsigned a,
                                                  longint unsigned b);
      longint unsigned lo, hi, mag;
      int u;
      u = 30 - FRAC;
      lo = (a & (ONE30 - 1)) * b;
      hi = (a >> 30) * b + (lo >> 30);
      mag = (hi + (64'd1 << (u - 1))) >> u;
      if (neg) begin
         if (mag >= 64'h8000_0000) return 32'h8000_0000;
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return 32'(mag);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // queue the sixteen column-major elements of proj*view*model for one angle
   function automatic void predict_matrix(logic [ANGLE_W-1:0] angle);
      longint unsigned w, g;
      longint sv, cv;
      logic s_pos, c_pos;
      logic [31:0] m[16];
      element_type e;
      w = model_width;
      if (w == 0) w = 1;
      g = (FOCAL30 * longint'(model_height) + w / 2) / w;
      angle_sincos(angle, sv, cv);
      s_pos = sv > 0;
      c_pos = cv > 0;
      foreach (m[k]) m[k] = '0;
      m[EL_G_COS] = scaled_element(cv < 0, g, magnitude(cv));
      m[EL_A_SIN] = scaled_element(s_pos, A30, magnitude(sv));
      m[EL_SIN]   = scaled_element(s_pos, ONE30, magnitude(sv));
      m[EL_FOCAL] = scaled_element(1'b0, FOCAL30, ONE30);
      m[EL_G_SIN] = scaled_element(s_pos, g, magnitude(sv));
      m[EL_A_COS] = scaled_element(c_pos, A30, magnitude(cv));
      m[EL_COS]   = scaled_element(c_pos, ONE30, magnitude(cv));
      m[EL_DEPTH] = scaled_element(1'b0, T30, ONE30);
      m[EL_LAST]  = scaled_element(1'b0, 64'd3 * ONE30, ONE30);
      for (int k = 0; k < 16; k++) begin
         e.index = IDX_W'(k);
         e.value = m[k];
         e.last  = (k == 15);
         pending_elements.push_back(e);
      end
   endfunction

   // ---------------- driver ----------------

   int burst_left = 0;
   int gap_left = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rotation_angle = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // transaction accepted at this edge
         if (req_ch.valid) begin
            predict_matrix(req_ch.rotation_angle);
            angles_sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (angle_backlog.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.rotation_angle <= angle_backlog.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // new burst; sometimes back to back with no gap at all
               burst_left = $urandom_range(0, 6);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver ----------------

   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int phase_tick = 0;

   always @(posedge clock) begin
      phase_tick++;
      if (hold_request && !hold_done) begin
         // long hold-off so the queue fills and the angle side backs up
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 120);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ch.ready <= (phase_tick % 5 != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         elements_seen++;
         if (pending_elements.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected element transaction idx=%0d value=%h last=%0b",
                        rsp_ch.element_index, rsp_ch.element_value, rsp_ch.last_element);
         end else begin
            want = pending_elements.pop_front();
            if (rsp_ch.element_index !== want.index || rsp_ch.element_value !== want.value
                || rsp_ch.last_element !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("element mismatch: expected idx=%0d value=%h last=%0b",
                           want.index, want.value, want.last);
                  $display("                  got      idx=%0d value=%h last=%0b",
                           rsp_ch.element_index, rsp_ch.element_value,
                           rsp_ch.last_element);
               end
            end
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [REG_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_WIDTH) model_width = data;
      else model_height = data;
   endtask

   task automatic set_aspect(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain_all();
      // sampled between edges so the driver's hand-off is settled
      do @(negedge clock);
      while (angle_backlog.size() != 0 || req_ch.valid || pending_elements.size() != 0);
      // let the element pipeline settle before touching the registers
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ANGLE_W-1:0] random_angle();
      // mostly the nominal 0..2pi range, sometimes the full field
      if ($urandom_range(0, 7) == 0) return ANGLE_W'($urandom_range(0, 524287));
      return ANGLE_W'($urandom_range(0, 411775));
   endfunction

   logic [REG_W-1:0] widths[8]  = '{13'd800, 13'd1, 13'd4096, 13'd1, 13'd0, 13'd8191,
                                    13'd0, 13'd1920};
   logic [REG_W-1:0] heights[8] = '{13'd600, 13'd1, 13'd1, 13'd4096, 13'd0, 13'd8191,
                                    13'd5, 13'd1080};

   initial begin
      // zero, quadrant and octant edges, two pi on both sides, field maximum
      logic [ANGLE_W-1:0] directed[$] = '{19'd0, 19'd1, 19'd25736, 19'd51472, 19'd51473,
                                          19'd102943, 19'd102944, 19'd205887, 19'd205888,
                                          19'd308831, 19'd308832, 19'd411774, 19'd411775,
                                          19'd524287, 19'd262143};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // phase 0 keeps reset aspect and runs the directed angles
      foreach (directed[i]) angle_backlog.push_back(directed[i]);
      drain_all();

      for (int p = 0; p < 8; p++) begin
         if (p == 0) set_aspect(widths[p], heights[p]);
         else if (p == 7) set_aspect(REG_W'($urandom_range(1, 8191)),
                                     REG_W'($urandom_range(1, 8191)));
         else set_aspect(widths[p], heights[p]);
         for (int n = 0; n < 15; n++) angle_backlog.push_back(random_angle());
         if (p == 2) hold_request = 1'b1;
         drain_all();
      end

      $display("covered %0d angles and %0d matrix elements over nine aspect settings",
               angles_sent, elements_seen);
      $display("including zero and full-scale registers, octant edges and a long output hold");
      if (mismatches == 0 && pending_elements.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
